>>> rtl/drhp_pkg.sv
package drhp_pkg;

  localparam int unsigned MAX_HOPS = 64;

  localparam logic [7:0] MAX_HOPS_W = 8'(MAX_HOPS);

  // function select codes
  typedef enum logic [1:0] {
    FN_SEND_CHECK = 2'd0,
    FN_RECV_CHECK = 2'd1,
    FN_CLASSIFY   = 2'd2,
    FN_NEXT_PORT  = 2'd3
  } func_t;

  // forward class codes
  localparam logic [1:0] CLS_LOCAL   = 2'd0;
  localparam logic [1:0] CLS_SEND    = 2'd1;
  localparam logic [1:0] CLS_FORWARD = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_IS_SWITCH  = 2'd0;
  localparam logic [1:0] REG_PORT_COUNT = 2'd1;

  typedef struct packed {
    logic       is_switch_node;
    logic [7:0] port_count;
  } cfg_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] hop_pointer;
    logic [7:0] hop_count;
    logic       returning;
    logic       source_permissive;
    logic       dest_permissive;
    logic [7:0] port_number;
    logic [7:0] initial_next;
    logic [7:0] return_prev;
  } item_t;

  typedef struct packed {
    logic       handle;
    logic [7:0] new_hop_pointer;
    logic       path_write;
    logic [7:0] path_write_index;
    logic [7:0] path_write_value;
    logic [1:0] forward_class;
    logic [7:0] next_port;
  } result_t;

endpackage

>>> rtl/drhp_cfg.sv
module drhp_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output drhp_pkg::cfg_t    cfg
);
  import drhp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_switch_node <= 1'b0;
      cfg.port_count     <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IS_SWITCH:  cfg.is_switch_node <= cfg_data[0];
        REG_PORT_COUNT: cfg.port_count     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/drhp_core.sv
module drhp_core (
  input  drhp_pkg::cfg_t    cfg,
  input  drhp_pkg::item_t   item,
  output drhp_pkg::result_t res
);
  import drhp_pkg::*;

  logic       sw;
  logic [7:0] p;
  logic [7:0] cnt;
  logic [8:0] cnt_p1;
  logic       too_many;
  logic       p_eq_cnt1;
  logic       fwd_mid;
  logic       ret_mid;
  logic       wr;

  assign sw        = cfg.is_switch_node;
  assign p         = item.hop_pointer;
  assign cnt       = item.hop_count;
  assign cnt_p1    = {1'b0, cnt} + 9'd1;
  assign too_many  = (cnt >= MAX_HOPS_W);
  assign p_eq_cnt1 = ({1'b0, p} == cnt_p1);
  // intermediate hops on the outbound and the return path
  assign fwd_mid   = (p != 8'd0) && (p < cnt);
  assign ret_mid   = (p >= 8'd2) && (p <= cnt);

  always_comb begin
    res                 = '0;
    res.new_hop_pointer = p;
    res.forward_class   = CLS_LOCAL;
    wr                  = 1'b0;
    case (item.func)
      FN_SEND_CHECK: begin
        if (too_many) begin
          res.handle = 1'b0;
        end else if (!item.returning) begin
          if (cnt != 8'd0 && p == 8'd0) begin
            res.new_hop_pointer = p + 8'd1;
            res.handle          = (item.initial_next == item.port_number);
          end else if (fwd_mid) begin
            if (sw) begin
              res.new_hop_pointer = p + 8'd1;
              res.handle          = (item.initial_next == item.port_number);
            end
          end else if (p == cnt) begin
            res.new_hop_pointer = p + 8'd1;
            res.handle          = sw | item.source_permissive;
          end else begin
            res.handle = p_eq_cnt1;
          end
        end else begin
          if (cnt != 8'd0 && p_eq_cnt1) begin
            res.new_hop_pointer = p - 8'd1;
            res.handle          = (item.return_prev == item.port_number);
          end else if (ret_mid) begin
            if (sw) begin
              res.new_hop_pointer = p - 8'd1;
              res.handle          = (item.return_prev == item.port_number);
            end
          end else if (p == 8'd1) begin
            res.new_hop_pointer = 8'd0;
            res.handle          = sw | item.dest_permissive;
          end else begin
            res.handle = (p == 8'd0);
          end
        end
      end
      FN_RECV_CHECK: begin
        if (too_many) begin
          res.handle = 1'b0;
        end else if (!item.returning) begin
          if (cnt != 8'd0 && p == 8'd0) begin
            res.handle = 1'b0;
          end else if (fwd_mid) begin
            if (sw) begin
              wr         = 1'b1;
              res.handle = (item.initial_next <= cfg.port_count);
            end
          end else if (p == cnt) begin
            wr         = (cnt != 8'd0);
            res.handle = sw | item.source_permissive;
          end else begin
            res.handle = p_eq_cnt1;
          end
        end else begin
          if (cnt != 8'd0 && p_eq_cnt1) begin
            res.new_hop_pointer = p - 8'd1;
            res.handle          = (item.return_prev == item.port_number);
          end else if (ret_mid) begin
            res.handle = sw && (item.return_prev <= cfg.port_count);
          end else if (p == 8'd1) begin
            if (item.dest_permissive) begin
              res.new_hop_pointer = 8'd0;
              res.handle          = 1'b1;
            end else begin
              res.handle = sw;
            end
          end else begin
            res.handle = (p == 8'd0);
          end
        end
      end
      FN_CLASSIFY: begin
        if (!item.returning) begin
          if (fwd_mid) begin
            res.forward_class = CLS_FORWARD;
          end else if (p == cnt) begin
            res.forward_class = item.source_permissive ? CLS_SEND : CLS_LOCAL;
          end else if (p_eq_cnt1) begin
            res.forward_class = CLS_SEND;
          end
        end else begin
          if (ret_mid) begin
            res.forward_class = CLS_FORWARD;
          end else if (p == 8'd1) begin
            res.forward_class = item.dest_permissive ? CLS_LOCAL : CLS_SEND;
          end
        end
      end
      FN_NEXT_PORT: begin
        res.next_port = item.returning ? item.return_prev : item.initial_next;
      end
      default: ;
    endcase
    res.path_write       = wr;
    res.path_write_index = wr ? p : 8'd0;
    res.path_write_value = wr ? item.port_number : 8'd0;
  end

endmodule

>>> rtl/directed_route_hop_processor.sv
// Directed-route SMP hop processor.
// A request passes through the input register, the hop logic and the result
// register. Throughput: one request per cycle while in_stall is low; in_stall
// rises only while both registers hold requests and out_stall is high.
// Reset (rst, synchronous, active high) empties the pipeline and clears
// is_switch_node and port_count to 0.
module directed_route_hop_processor (
  input  logic       clk,
  input  logic       rst,

  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] hop_pointer,
  input  logic [7:0] hop_count,
  input  logic       returning,
  input  logic       source_permissive,
  input  logic       dest_permissive,
  input  logic [7:0] port_number,
  input  logic [7:0] initial_next,
  input  logic [7:0] return_prev,

  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       handle,
  output logic [7:0] new_hop_pointer,
  output logic       path_write,
  output logic [7:0] path_write_index,
  output logic [7:0] path_write_value,
  output logic [1:0] forward_class,
  output logic [7:0] next_port,

  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import drhp_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t core_res;
  result_t s2_res;
  logic    s2_valid;
  logic    s2_take;
  logic    s1_take;

  // Register writes are always taken; software must only write while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  drhp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Result register loads whenever it is empty or being drained this cycle.
  assign s2_take  = !s2_valid || !out_stall;
  // Input register loads whenever it is empty or moves into the result stage.
  assign s1_take  = !s1_valid || s2_take;
  assign in_stall = !s1_take;

  // stage 1: request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_item.func              <= func_t'(func);
      s1_item.hop_pointer       <= hop_pointer;
      s1_item.hop_count         <= hop_count;
      s1_item.returning         <= returning;
      s1_item.source_permissive <= source_permissive;
      s1_item.dest_permissive   <= dest_permissive;
      s1_item.port_number       <= port_number;
      s1_item.initial_next      <= initial_next;
      s1_item.return_prev       <= return_prev;
    end
  end

  // hop checks, classification and port lookup
  drhp_core u_core (
    .cfg  (cfg),
    .item (s1_item),
    .res  (core_res)
  );

  // stage 2: result register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      s2_res <= core_res;
    end
  end

  assign out_valid        = s2_valid;
  assign handle           = s2_res.handle;
  assign new_hop_pointer  = s2_res.new_hop_pointer;
  assign path_write       = s2_res.path_write;
  assign path_write_index = s2_res.path_write_index;
  assign path_write_value = s2_res.path_write_value;
  assign forward_class    = s2_res.forward_class;
  assign next_port        = s2_res.next_port;

endmodule

>>> rtl/drhp_checker.sv
module drhp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       handle,
  input logic [7:0] new_hop_pointer,
  input logic       path_write,
  input logic [7:0] path_write_index,
  input logic [7:0] path_write_value,
  input logic [1:0] forward_class,
  input logic [7:0] next_port
);
  import drhp_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_hop_pointer)
      && $stable(handle) && $stable(next_port) && $stable(forward_class))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_class: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> forward_class != 2'd3)
    else $error("undefined forward class");

  // no return-path write means zero index and value
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !path_write |-> path_write_index == 8'd0
      && path_write_value == 8'd0)
    else $error("write fields set without path write");

  // a classification result carries no check or lookup outputs
  a_cls_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && forward_class != CLS_LOCAL |->
      !handle && !path_write && next_port == 8'd0)
    else $error("classification mixed with other outputs");

endmodule

bind directed_route_hop_processor drhp_checker u_drhp_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .handle           (handle),
  .new_hop_pointer  (new_hop_pointer),
  .path_write       (path_write),
  .path_write_index (path_write_index),
  .path_write_value (path_write_value),
  .forward_class    (forward_class),
  .next_port        (next_port)
);

>>> test/tb_directed_route_hop_processor.sv
`timescale 1ns / 1ps

module tb_directed_route_hop_processor;
  import drhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4;  // pipeline is two deep, plus margin
  localparam int unsigned RANDOM_PER_PHASE = 250;

  // Every block input starts at a known value.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [7:0] hop_pointer = '0;
  logic [7:0] hop_count = '0;
  logic       returning = 1'b0;
  logic       source_permissive = 1'b0;
  logic       dest_permissive = 1'b0;
  logic [7:0] port_number = '0;
  logic [7:0] initial_next = '0;
  logic [7:0] return_prev = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       handle;
  logic [7:0] new_hop_pointer;
  logic       path_write;
  logic [7:0] path_write_index;
  logic [7:0] path_write_value;
  logic [1:0] forward_class;
  logic [7:0] next_port;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  directed_route_hop_processor i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .hop_pointer       (hop_pointer),
    .hop_count         (hop_count),
    .returning         (returning),
    .source_permissive (source_permissive),
    .dest_permissive   (dest_permissive),
    .port_number       (port_number),
    .initial_next      (initial_next),
    .return_prev       (return_prev),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .handle            (handle),
    .new_hop_pointer   (new_hop_pointer),
    .path_write        (path_write),
    .path_write_index  (path_write_index),
    .path_write_value  (path_write_value),
    .forward_class     (forward_class),
    .next_port         (next_port),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Directed row: request plus, where obvious, the hand-written answer.
  typedef struct {
    item_t   rq;
    bit      typed;
    result_t want;
  } hop_row_t;

  hop_row_t    hop_table[$];
  result_t     results_due[$];   // predicted results, oldest first
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Local copy of the node configuration, tracks what was written.
  logic        sw_node = 1'b0;
  logic [7:0]  port_total = '0;

  // Traffic shaping, shared between the main sequence and the result side.
  bit          no_idle = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;

  initial forever #5 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, results_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Hop predictor: what the node decides for one request under the current
  // switch flag and port count.
  // ---------------------------------------------------------------------------
  function automatic result_t predict_hop(item_t rq);
    result_t    r;
    logic [7:0] p;
    logic [7:0] cnt;
    logic [8:0] cnt_up;   // hop_count + 1 kept at 9 bits, never wraps onto a pointer
    logic [8:0] p_wide;
    logic       hop_ok;
    r      = '0;
    p      = rq.hop_pointer;
    cnt    = rq.hop_count;
    cnt_up = {1'b0, cnt} + 9'd1;
    p_wide = {1'b0, p};
    hop_ok = cnt < MAX_HOPS_W;
    r.new_hop_pointer = p;
    case (rq.func)
      FN_SEND_CHECK: begin
        if (hop_ok && !rq.returning) begin
          if (cnt != 0 && p == 0) begin
            r.new_hop_pointer = p + 8'd1;
            r.handle = rq.initial_next == rq.port_number;
          end else if (p != 0 && p < cnt) begin
            // mid-path hop only a switch may take
            if (sw_node) begin
              r.new_hop_pointer = p + 8'd1;
              r.handle = rq.initial_next == rq.port_number;
            end
          end else if (p == cnt) begin
            r.new_hop_pointer = p + 8'd1;
            r.handle = sw_node || rq.source_permissive;
          end else begin
            r.handle = p_wide == cnt_up;
          end
        end else if (hop_ok) begin
          if (cnt != 0 && p_wide == cnt_up) begin
            r.new_hop_pointer = p - 8'd1;
            r.handle = rq.return_prev == rq.port_number;
          end else if (p >= 2 && p <= cnt) begin
            if (sw_node) begin
              r.new_hop_pointer = p - 8'd1;
              r.handle = rq.return_prev == rq.port_number;
            end
          end else if (p == 1) begin
            r.new_hop_pointer = '0;
            r.handle = sw_node || rq.dest_permissive;
          end else begin
            r.handle = p == 0;
          end
        end
      end
      FN_RECV_CHECK: begin
        if (hop_ok && !rq.returning) begin
          if (cnt != 0 && p == 0) begin
            r.handle = 1'b0;
          end else if (p != 0 && p < cnt) begin
            if (sw_node) begin
              r.path_write = 1'b1;
              r.handle = rq.initial_next <= port_total;
            end
          end else if (p == cnt) begin
            r.path_write = cnt != 0;
            r.handle = sw_node || rq.source_permissive;
          end else begin
            r.handle = p_wide == cnt_up;
          end
        end else if (hop_ok) begin
          if (cnt != 0 && p_wide == cnt_up) begin
            r.new_hop_pointer = p - 8'd1;
            r.handle = rq.return_prev == rq.port_number;
          end else if (p >= 2 && p <= cnt) begin
            r.handle = sw_node && (rq.return_prev <= port_total);
          end else if (p == 1) begin
            if (rq.dest_permissive) begin
              r.new_hop_pointer = '0;
              r.handle = 1'b1;
            end else begin
              r.handle = sw_node;
            end
          end else begin
            r.handle = p == 0;
          end
        end
        if (r.path_write) begin
          r.path_write_index = p;
          r.path_write_value = rq.port_number;
        end
      end
      FN_CLASSIFY: begin
        // no hop count limit here
        if (!rq.returning) begin
          if (p != 0 && p < cnt) begin
            r.forward_class = CLS_FORWARD;
          end else if (p == cnt) begin
            r.forward_class = rq.source_permissive ? CLS_SEND : CLS_LOCAL;
          end else if (p_wide == cnt_up) begin
            r.forward_class = CLS_SEND;
          end
        end else begin
          if (p >= 2 && p <= cnt) begin
            r.forward_class = CLS_FORWARD;
          end else if (p == 1) begin
            r.forward_class = rq.dest_permissive ? CLS_LOCAL : CLS_SEND;
          end
        end
      end
      default: begin
        r.next_port = rq.returning ? rq.return_prev : rq.initial_next;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 23);
    end
  end

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] seen);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
    mismatches++;
  endtask

  // Compare each accepted result against the oldest prediction.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{handle, new_hop_pointer, path_write, path_write_index, path_write_value,
               forward_class, next_port};
      if (results_due.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %h", $time, seen);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (seen.handle !== want.handle)
          report_mismatch("handle", want.handle, seen.handle);
        if (seen.new_hop_pointer !== want.new_hop_pointer)
          report_mismatch("new_hop_pointer", want.new_hop_pointer, seen.new_hop_pointer);
        if (seen.path_write !== want.path_write)
          report_mismatch("path_write", want.path_write, seen.path_write);
        if (seen.path_write_index !== want.path_write_index)
          report_mismatch("path_write_index", want.path_write_index, seen.path_write_index);
        if (seen.path_write_value !== want.path_write_value)
          report_mismatch("path_write_value", want.path_write_value, seen.path_write_value);
        if (seen.forward_class !== want.forward_class)
          report_mismatch("forward_class", want.forward_class, seen.forward_class);
        if (seen.next_port !== want.next_port)
          report_mismatch("next_port", want.next_port, seen.next_port);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, with random gaps ahead of it; returns on the
  // accepting edge. Valid stays up so a back-to-back request needs no toggle.
  task automatic send_request(item_t rq, result_t want);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    func              <= rq.func;
    hop_pointer       <= rq.hop_pointer;
    hop_count         <= rq.hop_count;
    returning         <= rq.returning;
    source_permissive <= rq.source_permissive;
    dest_permissive   <= rq.dest_permissive;
    port_number       <= rq.port_number;
    initial_next      <= rq.initial_next;
    return_prev       <= rq.return_prev;
    do @(posedge clk); while (in_stall);
    results_due.push_back(want);
  endtask

  // Stop offering and wait for every pending result.
  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Both registers in one burst; block must be idle.
  task automatic write_config(logic sw, logic [7:0] ports);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IS_SWITCH;
    cfg_data  <= {7'd0, sw};
    do @(posedge clk); while (!cfg_ready);
    sw_node = sw;
    cfg_index <= REG_PORT_COUNT;
    cfg_data  <= ports;
    do @(posedge clk); while (!cfg_ready);
    port_total = ports;
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t req(func_t f, logic [7:0] hp, logic [7:0] cnt, logic ret,
                                logic sp, logic dp, logic [7:0] port, logic [7:0] inx,
                                logic [7:0] rpv);
    return '{f, hp, cnt, ret, sp, dp, port, inx, rpv};
  endfunction

  function automatic result_t res(logic h, logic [7:0] nhp, logic pw, logic [7:0] idx,
                                  logic [7:0] val, logic [1:0] cls, logic [7:0] np);
    return '{h, nhp, pw, idx, val, cls, np};
  endfunction

  // Mostly well-formed headers: small hop counts with the pointer anywhere from
  // zero to two past the path end, and path entries that match the port or lie
  // at most one above the port count. The rest is unconstrained noise and over-long paths.
  function automatic item_t random_request();
    item_t       rq;
    int unsigned cnt;
    int unsigned pick;
    rq.func              = func_t'($urandom_range(3));
    rq.returning         = 1'($urandom_range(1));
    rq.source_permissive = 1'($urandom_range(1));
    rq.dest_permissive   = 1'($urandom_range(1));
    rq.port_number       = 8'($urandom);
    rq.initial_next      = 8'($urandom);
    rq.return_prev       = 8'($urandom);
    rq.hop_pointer       = 8'($urandom);
    rq.hop_count         = 8'($urandom);
    pick = $urandom_range(99);
    if (pick >= 15) begin
      if (pick < 22) cnt = $urandom_range(255, MAX_HOPS - 2);
      else if (pick < 35) cnt = $urandom_range(MAX_HOPS - 1);
      else cnt = $urandom_range(6);
      rq.hop_count   = 8'(cnt);
      rq.hop_pointer = 8'($urandom_range(cnt + 2));
      if ($urandom_range(1)) rq.initial_next = rq.port_number;
      else rq.initial_next = 8'($urandom_range(port_total + 1));
      if ($urandom_range(1)) rq.return_prev = rq.port_number;
      else rq.return_prev = 8'($urandom_range(port_total + 1));
    end
    return rq;
  endfunction

  task automatic run_table(bit use_typed);
    foreach (hop_table[i]) begin
      if (use_typed && hop_table[i].typed)
        send_request(hop_table[i].rq, hop_table[i].want);
      else
        send_request(hop_table[i].rq, predict_hop(hop_table[i].rq));
    end
  endtask

  // pause_at: request index before which the sender waits for a full drain
  task automatic run_random(int unsigned count, int pause_at);
    item_t rq;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) drain();
      rq = random_request();
      send_request(rq, predict_hop(rq));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed table. Typed answers assume the reset configuration
    // (endpoint, zero ports).
    // hop count at the limit: discard, pointer untouched
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd5, 8'd64, 1'b0, 1'b1, 1'b1, 8'd5, 8'd5, 8'd5),
                          1'b1, res(1'b0, 8'd5, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF,
                              8'hFF),
                          1'b1, res(1'b0, 8'hFF, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    // count of 255: count + 1 must not wrap onto a zero pointer
    hop_table.push_back('{req(FN_CLASSIFY, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b1, res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b1, res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    // next port, return path with pointer at zero: entry passed through
    hop_table.push_back('{req(FN_NEXT_PORT, 8'd0, 8'd3, 1'b1, 1'b0, 1'b0, 8'd1, 8'd2, 8'hA5),
                          1'b1, res(1'b0, 8'd0, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'hA5)});
    hop_table.push_back('{req(FN_NEXT_PORT, 8'hFF, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF,
                              8'h00),
                          1'b1, res(1'b0, 8'hFF, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'hFF)});
    // send, outbound, first hop
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd0, 8'd3, 1'b0, 1'b0, 1'b0, 8'd7, 8'd7, 8'd0),
                          1'b1, res(1'b1, 8'd1, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    // mid-path hop on an endpoint: discard
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd2, 8'd3, 1'b0, 1'b0, 1'b0, 8'd7, 8'd7, 8'd0),
                          1'b1, res(1'b0, 8'd2, 1'b0, 8'd0, 8'd0, CLS_LOCAL, 8'd0)});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd3, 8'd3, 1'b0, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1),
                          1'b0, '0});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd4, 8'd3, 1'b0, 1'b0, 1'b0, 8'd1, 8'd1, 8'd1),
                          1'b0, '0});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd4, 8'd3, 1'b1, 1'b0, 1'b0, 8'd9, 8'd0, 8'd9),
                          1'b0, '0});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd1, 8'd3, 1'b1, 1'b0, 1'b1, 8'd9, 8'd0, 8'd9),
                          1'b0, '0});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd0, 8'd3, 1'b1, 1'b0, 1'b0, 8'd9, 8'd0, 8'd9),
                          1'b0, '0});
    hop_table.push_back('{req(FN_SEND_CHECK, 8'd63, 8'd63, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF,
                              8'hFF),
                          1'b0, '0});
    // receive checks
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd0, 8'd2, 1'b0, 1'b0, 1'b0, 8'd4, 8'd4, 8'd4),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd1, 8'd3, 1'b0, 1'b0, 1'b0, 8'd4, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd3, 8'd3, 1'b0, 1'b1, 1'b0, 8'hFF, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd6, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd3, 8'd2, 1'b1, 1'b0, 1'b0, 8'd5, 8'd0, 8'd5),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd1, 8'd4, 1'b1, 1'b0, 1'b1, 8'd5, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd1, 8'd4, 1'b1, 1'b0, 1'b0, 8'd5, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_RECV_CHECK, 8'd2, 8'd5, 1'b1, 1'b0, 1'b0, 8'd5, 8'd0, 8'd0),
                          1'b0, '0});
    // forward classes
    hop_table.push_back('{req(FN_CLASSIFY, 8'd1, 8'd3, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_CLASSIFY, 8'd1, 8'd3, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_CLASSIFY, 8'd3, 8'd3, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b0, '0});
    hop_table.push_back('{req(FN_CLASSIFY, 8'd4, 8'd3, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0),
                          1'b0, '0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under reset configuration, then again as a full switch.
    run_table(1'b1);
    drain();
    write_config(1'b1, 8'hFF);
    run_table(1'b0);
    drain();

    // Long stretch with no idling on either side.
    no_idle = 1'b1;
    run_random(RANDOM_PER_PHASE, -1);
    drain();
    no_idle = 1'b0;

    // Endpoint; result side holds off long enough to back up the pipe.
    write_config(1'b0, 8'hFF);
    hold_asked++;
    run_random(RANDOM_PER_PHASE, -1);
    drain();

    // Switch with no ports; sender pauses midway until all results are in.
    write_config(1'b1, 8'd0);
    run_random(RANDOM_PER_PHASE, RANDOM_PER_PHASE / 2);
    drain();

    write_config(1'b1, 8'($urandom));
    run_random(RANDOM_PER_PHASE, -1);
    drain();

    write_config(1'b0, 8'($urandom));
    run_random(RANDOM_PER_PHASE, -1);
    drain();

    write_config(1'b1, 8'd8);
    run_random(RANDOM_PER_PHASE, -1);
    drain();

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/drhp_pkg.sv
rtl/drhp_cfg.sv
rtl/drhp_core.sv
rtl/directed_route_hop_processor.sv
rtl/drhp_checker.sv
test/tb_directed_route_hop_processor.sv
